// ===== rtl/gradient_noise_2d_sampler_assert.svh =====
// Assertion macros for the gradient noise sampler.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef GRADIENT_NOISE_2D_SAMPLER_ASSERT_SVH
`define GRADIENT_NOISE_2D_SAMPLER_ASSERT_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge outside reset.
`define GNS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define GNS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define GNS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define GNS_ASSERT_ALWAYS(label, cond, msg)
`define GNS_ASSERT_IMPL(label, ante, cons, msg)
`define GNS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/gns_pkg.sv =====
// Shared constants, types and the gradient selection function of the noise sampler.
// No dependencies; imported by every module of the block but gns_ram.
`timescale 1ns / 1ps

package gns_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned CELL_W      = 8;
  localparam int unsigned COORD_W     = CELL_W + FRAC_BITS;
  localparam int unsigned TABLE_DEPTH = 1 << CELL_W;
  localparam int unsigned FADE_W      = FRAC_BITS + 1;
  localparam int unsigned BLEND_W     = FRAC_BITS + 4;
  localparam int unsigned GRAD_W      = FRAC_BITS + 3;
  localparam int unsigned DIFF_W      = GRAD_W + 1;
  localparam int unsigned PROD_W      = FADE_W + 1 + DIFF_W;
  localparam int unsigned TEN_ONE     = 10 * (1 << FRAC_BITS);
  localparam int unsigned NUM_STAGES  = 9;
  localparam int unsigned S_TDATA_W   = 64;
  localparam int unsigned M_TDATA_W   = 24;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    GRAD_PX_PY = 3'd0,
    GRAD_PX_NY = 3'd1,
    GRAD_NX_PY = 3'd2,
    GRAD_NX_NY = 3'd3,
    GRAD_PX    = 3'd4,
    GRAD_PY    = 3'd5,
    GRAD_NX    = 3'd6,
    GRAD_NY    = 3'd7
  } grad_e;

  // Bit k advances pipeline stage k.
  typedef logic [NUM_STAGES:1] stage_en_t;

  typedef struct packed {
    logic [CELL_W-1:0] aa;
    logic [CELL_W-1:0] ab;
    logic [CELL_W-1:0] ba;
    logic [CELL_W-1:0] bb;
  } hash_set_t;

  function automatic logic signed [GRAD_W-1:0] grad_value(
    input logic [CELL_W-1:0]         hash,
    input logic signed [FRAC_BITS:0] dx,
    input logic signed [FRAC_BITS:0] dy
  );
    logic signed [GRAD_W-1:0] ex;
    logic signed [GRAD_W-1:0] ey;
    logic signed [GRAD_W-1:0] res;
    ex = GRAD_W'(dx);
    ey = GRAD_W'(dy);
    case (grad_e'(hash[2:0]))
      GRAD_PX_PY: res = ex + ey;
      GRAD_PX_NY: res = ex - ey;
      GRAD_NX_PY: res = ey - ex;
      GRAD_NX_NY: res = -ex - ey;
      GRAD_PX:    res = ex;
      GRAD_PY:    res = ey;
      GRAD_NX:    res = -ex;
      GRAD_NY:    res = -ey;
      default:    res = '0;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/gns_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gns_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== rtl/gns_fade.sv =====
// Quintic fade 6t^5 - 15t^4 + 10t^3 of one fraction, over pipeline stages 1 to 4.
// Depends on gns_pkg.
`timescale 1ns / 1ps

module gns_fade import gns_pkg::*; (
  input  logic                 clk_i,
  input  stage_en_t            en_i,
  input  logic [FRAC_BITS-1:0] frac_i,
  output logic [FADE_W-1:0]    fade_o
);

  logic [FRAC_BITS-1:0]     t1_q;
  logic [2*FRAC_BITS-1:0]   sq_d, sq_q;
  logic [2*FRAC_BITS+2:0]   six_sq;
  logic [2*FRAC_BITS-1:0]   t3p_d, t3p_q;
  logic [BLEND_W-1:0]       b_d, b_q;
  logic [FRAC_BITS+BLEND_W-1:0] fp_d, fp_q;
  logic [FADE_W-1:0]        fade_d, fade_q;

  assign sq_d = (2*FRAC_BITS)'(frac_i) * (2*FRAC_BITS)'(frac_i);

  // t*(6t - 15) reduces to floor(6t^2) - 15t, since 15t has no fraction bits.
  assign six_sq = ((2*FRAC_BITS+3)'(sq_q) << 1) + ((2*FRAC_BITS+3)'(sq_q) << 2);
  assign b_d    = BLEND_W'((BLEND_W+1)'(six_sq[2*FRAC_BITS+2:FRAC_BITS])
                         + (BLEND_W+1)'(TEN_ONE)
                         - (BLEND_W+1)'(t1_q) * (BLEND_W+1)'(15));
  assign t3p_d  = (2*FRAC_BITS)'(sq_q[2*FRAC_BITS-1:FRAC_BITS]) * (2*FRAC_BITS)'(t1_q);

  assign fp_d   = (FRAC_BITS+BLEND_W)'(t3p_q[2*FRAC_BITS-1:FRAC_BITS])
                * (FRAC_BITS+BLEND_W)'(b_q);
  assign fade_d = fp_q[FRAC_BITS+FADE_W-1:FRAC_BITS];

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      t1_q <= frac_i;
      sq_q <= sq_d;
    end
    if (en_i[2]) begin
      t3p_q <= t3p_d;
      b_q   <= b_d;
    end
    if (en_i[3]) begin
      fp_q <= fp_d;
    end
    if (en_i[4]) begin
      fade_q <= fade_d;
    end
  end

  assign fade_o = fade_q;

endmodule

// ===== rtl/gns_hash.sv =====
// Corner hashing: permutation table copies and the two dependent lookups (stages 1 and 2).
// Depends on gns_pkg and gns_ram.
`timescale 1ns / 1ps

module gns_hash import gns_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stage_en_t         en_i,
  input  logic              wr_i,
  input  logic [CELL_W-1:0] idx_i,
  input  logic [CELL_W-1:0] val_i,
  input  logic [CELL_W-1:0] cx_i,
  input  logic [CELL_W-1:0] cy_i,
  output logic              wr_pend_o,
  output hash_set_t         hash_o
);

  logic              w1_q;
  logic [CELL_W-1:0] idx1_q;
  logic [CELL_W-1:0] val1_q;
  logic [CELL_W-1:0] cy1_q;
  logic [CELL_W-1:0] h0, h1;
  logic              wr2;

  // Each copy is written as the write beat passes the stage where that copy
  // is read, so every sample sees exactly the writes that came before it.
  assign wr2 = en_i[2] & w1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w1_q <= 1'b0;
    end else if (en_i[1]) begin
      w1_q <= wr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      idx1_q <= idx_i;
      val1_q <= val_i;
      cy1_q  <= cy_i;
    end
  end

  gns_ram #(
    .WIDTH (CELL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram_row (
    .clk_i     (clk_i),
    .we_i      (wr_i),
    .waddr_i   (idx_i),
    .wdata_i   (val_i),
    .re_i      (en_i[1]),
    .raddr_a_i (cx_i),
    .raddr_b_i (cx_i + CELL_W'(1)),
    .rdata_a_o (h0),
    .rdata_b_o (h1)
  );

  gns_ram #(
    .WIDTH (CELL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram_col0 (
    .clk_i     (clk_i),
    .we_i      (wr2),
    .waddr_i   (idx1_q),
    .wdata_i   (val1_q),
    .re_i      (en_i[2]),
    .raddr_a_i (h0 + cy1_q),
    .raddr_b_i (h0 + cy1_q + CELL_W'(1)),
    .rdata_a_o (hash_o.aa),
    .rdata_b_o (hash_o.ba)
  );

  gns_ram #(
    .WIDTH (CELL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram_col1 (
    .clk_i     (clk_i),
    .we_i      (wr2),
    .waddr_i   (idx1_q),
    .wdata_i   (val1_q),
    .re_i      (en_i[2]),
    .raddr_a_i (h1 + cy1_q),
    .raddr_b_i (h1 + cy1_q + CELL_W'(1)),
    .rdata_a_o (hash_o.ab),
    .rdata_b_o (hash_o.bb)
  );

  assign wr_pend_o = w1_q;

endmodule

// ===== rtl/gradient_noise_2d_sampler.sv =====
// 2D gradient noise sampler top level: stage control, gradients and blending.
// Depends on gns_pkg, gns_fade, gns_hash and gradient_noise_2d_sampler_assert.svh.
`timescale 1ns / 1ps
`include "gradient_noise_2d_sampler_assert.svh"

// Usage:
// Input beats arrive on the s_axis channel. tuser selects the kind of beat:
// a table write stores table_value at table_index in the 256-entry
// permutation table and returns nothing; a sample beat carries unsigned
// Q8.16 coordinates and returns one signed Q2.16 noise value on m_axis.
// The table must be loaded before it is sampled; it is not cleared by reset.
// Throughput is one beat per cycle, writes and samples freely mixed,
// while m_axis does not stall. A sample passes through the nine-stage
// pipeline: two dependent table reads, the fade multiplies and three
// interpolation multiplies, the last one chained on the other two.
// Every stage has its own valid bit and moves whenever the stage after it
// is empty or moving, so a stall on m_axis only stops the stages that are
// full; s_axis_tready stays high while any bubble is left in the pipeline.
// Reset (rst_ni low) empties the pipeline; no result is lost or repeated
// across a stall.

module gradient_noise_2d_sampler import gns_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata: table_index[7:0], table_value[15:8], coord_x[39:16], coord_y[63:40]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // tuser: operation[0]
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata: noise_value[18:0], zero[23:19]
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  stage_en_t               en;
  logic [NUM_STAGES:1]     vld_q;
  logic                    accept;
  logic                    acc_wr;
  logic                    acc_smp;
  logic                    wr_pend;
  hash_set_t               hash;

  logic [CELL_W-1:0]       tbl_idx, tbl_val;
  logic [COORD_W-1:0]      coord_x, coord_y;
  logic [FADE_W-1:0]       fade_u, fade_v;

  logic [FRAC_BITS-1:0]    fx1_q, fy1_q, fx2_q, fy2_q;
  logic signed [FRAC_BITS:0] dx0, dx1, dy0, dy1;
  logic signed [GRAD_W-1:0]  g0_q, g1_q, g2_q, g3_q;
  logic signed [DIFF_W-1:0]  d0_q, d1_q;
  logic signed [GRAD_W-1:0]  g0_4_q, g2_4_q, g0_5_q, g2_5_q;
  logic [FADE_W-1:0]         v5_q, v6_q, v7_q;
  logic signed [FADE_W:0]    u_s, v_s;
  logic signed [PROD_W-1:0]  m0_q, m1_q, mr_q;
  logic signed [GRAD_W-1:0]  r0_q, r1_q, r0_7_q, r0_8_q;
  logic signed [DIFF_W-1:0]  dr_q;
  logic signed [GRAD_W-1:0]  out_q;

  assign tbl_idx = s_axis_tdata[7:0];
  assign tbl_val = s_axis_tdata[15:8];
  assign coord_x = s_axis_tdata[39:16];
  assign coord_y = s_axis_tdata[63:40];

  // A stage moves when it is empty or when the stage after it moves.
  always_comb begin
    en[NUM_STAGES] = !vld_q[NUM_STAGES] || m_axis_tready;
    for (int k = NUM_STAGES - 1; k >= 2; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    en[1] = !(vld_q[1] || wr_pend) || en[2];
  end

  assign s_axis_tready = en[1];
  assign accept        = s_axis_tvalid && en[1];
  assign acc_wr        = accept && (op_e'(s_axis_tuser) == OP_WRITE);
  assign acc_smp       = accept && (op_e'(s_axis_tuser) == OP_SAMPLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[1]) begin
        vld_q[1] <= acc_smp;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  gns_hash u_hash (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .wr_i      (acc_wr),
    .idx_i     (tbl_idx),
    .val_i     (tbl_val),
    .cx_i      (coord_x[COORD_W-1:FRAC_BITS]),
    .cy_i      (coord_y[COORD_W-1:FRAC_BITS]),
    .wr_pend_o (wr_pend),
    .hash_o    (hash)
  );

  gns_fade u_fade_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .frac_i (coord_x[FRAC_BITS-1:0]),
    .fade_o (fade_u)
  );

  gns_fade u_fade_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .frac_i (coord_y[FRAC_BITS-1:0]),
    .fade_o (fade_v)
  );

  // Offsets to the far corner are the fraction minus one, which is the
  // fraction with a set sign bit on top.
  assign dx0 = signed'({1'b0, fx2_q});
  assign dx1 = signed'({1'b1, fx2_q});
  assign dy0 = signed'({1'b0, fy2_q});
  assign dy1 = signed'({1'b1, fy2_q});

  assign u_s = signed'({1'b0, fade_u});
  assign v_s = signed'({1'b0, v7_q});

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      fx1_q <= coord_x[FRAC_BITS-1:0];
      fy1_q <= coord_y[FRAC_BITS-1:0];
    end
    if (en[2]) begin
      fx2_q <= fx1_q;
      fy2_q <= fy1_q;
    end
    if (en[3]) begin
      g0_q <= grad_value(hash.aa, dx0, dy0);
      g1_q <= grad_value(hash.ab, dx1, dy0);
      g2_q <= grad_value(hash.ba, dx0, dy1);
      g3_q <= grad_value(hash.bb, dx1, dy1);
    end
    if (en[4]) begin
      d0_q   <= DIFF_W'(g1_q) - DIFF_W'(g0_q);
      d1_q   <= DIFF_W'(g3_q) - DIFF_W'(g2_q);
      g0_4_q <= g0_q;
      g2_4_q <= g2_q;
    end
    if (en[5]) begin
      m0_q   <= PROD_W'(u_s) * PROD_W'(d0_q);
      m1_q   <= PROD_W'(u_s) * PROD_W'(d1_q);
      g0_5_q <= g0_4_q;
      g2_5_q <= g2_4_q;
      v5_q   <= fade_v;
    end
    if (en[6]) begin
      // Arithmetic shift floors the product, as the blend requires.
      r0_q <= g0_5_q + GRAD_W'(m0_q >>> FRAC_BITS);
      r1_q <= g2_5_q + GRAD_W'(m1_q >>> FRAC_BITS);
      v6_q <= v5_q;
    end
    if (en[7]) begin
      dr_q   <= DIFF_W'(r1_q) - DIFF_W'(r0_q);
      r0_7_q <= r0_q;
      v7_q   <= v6_q;
    end
    if (en[8]) begin
      mr_q   <= PROD_W'(v_s) * PROD_W'(dr_q);
      r0_8_q <= r0_7_q;
    end
    if (en[9]) begin
      out_q <= r0_8_q + GRAD_W'(mr_q >>> FRAC_BITS);
    end
  end

  assign m_axis_tvalid = vld_q[NUM_STAGES];
  assign m_axis_tdata  = {{(M_TDATA_W-GRAD_W){1'b0}}, out_q};

  `GNS_ASSERT_NEXT(a_write_makes_no_sample, acc_wr, !vld_q[1] && wr_pend, "table write entered as a sample")
  `GNS_ASSERT_ALWAYS(a_stage1_single, !(vld_q[1] && wr_pend), "stage 1 holds a write and a sample")
  `GNS_ASSERT_IMPL(a_result_has_source, $rose(m_axis_tvalid), $past(vld_q[NUM_STAGES-1]), "result without a sample behind it")

endmodule

// ===== tb/sv/gradient_noise_2d_sampler_tb.sv =====
// Self-checking testbench for the 2D gradient noise sampler: table loads,
// directed and random samples under several handshake idle patterns.
// Depends on gns_pkg and the gradient_noise_2d_sampler RTL.
`timescale 1ns / 1ps

module gradient_noise_2d_sampler_tb;
  import gns_pkg::*;

  localparam int unsigned PHASE_ITEMS = 32;
  localparam int unsigned HOLD_AT     = 274;
  localparam int unsigned HOLD_CYCLES = 80;

  typedef struct {
    op_e               op;
    logic [CELL_W-1:0] index;
    logic [CELL_W-1:0] value;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } beat_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  beat_t       pending_beats[$];
  logic [18:0] expected_noise_q[$];
  logic [7:0]  perm_copy[TABLE_DEPTH];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned beats_queued = 0;
  int unsigned beats_taken = 0;
  int unsigned writes_taken = 0;
  int unsigned samples_taken = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic        in_accepted = 1'b0;

  gradient_noise_2d_sampler i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Fixed-point product of two Q.16 values, truncated toward minus infinity.
  function automatic longint fix_mul(longint a, longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic longint fade_curve(longint t);
    longint one;
    longint inner;
    longint t2;
    longint t3;
    one = longint'(1) << FRAC_BITS;
    inner = fix_mul(t, 6 * t - 15 * one) + 10 * one;
    t2 = fix_mul(t, t);
    t3 = fix_mul(t2, t);
    return fix_mul(t3, inner);
  endfunction

  function automatic longint blend(longint a, longint b, longint w);
    return a + fix_mul(w, b - a);
  endfunction

  function automatic longint corner_dot(logic [7:0] hash, longint dx, longint dy);
    case (grad_e'(hash[2:0]))
      GRAD_PX_PY: return dx + dy;
      GRAD_PX_NY: return dx - dy;
      GRAD_NX_PY: return dy - dx;
      GRAD_NX_NY: return -dx - dy;
      GRAD_PX:    return dx;
      GRAD_PY:    return dy;
      GRAD_NX:    return -dx;
      default:    return -dy;
    endcase
  endfunction

  function automatic logic [7:0] corner_hash(logic [7:0] cx, logic [7:0] cy);
    logic [7:0] first;
    first = perm_copy[cx];
    return perm_copy[8'(first + cy)];
  endfunction

  function automatic logic [18:0] noise_at(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    logic [7:0] cx;
    logic [7:0] cy;
    longint     one;
    longint     fx;
    longint     fy;
    longint     u;
    longint     v;
    longint     g0;
    longint     g1;
    longint     g2;
    longint     g3;
    longint     r;
    cx = x[COORD_W-1:FRAC_BITS];
    cy = y[COORD_W-1:FRAC_BITS];
    one = longint'(1) << FRAC_BITS;
    fx = longint'(x[FRAC_BITS-1:0]);
    fy = longint'(y[FRAC_BITS-1:0]);
    u = fade_curve(fx);
    v = fade_curve(fy);
    g0 = corner_dot(corner_hash(cx, cy), fx, fy);
    g1 = corner_dot(corner_hash(cx + 8'd1, cy), fx - one, fy);
    g2 = corner_dot(corner_hash(cx, cy + 8'd1), fx, fy - one);
    g3 = corner_dot(corner_hash(cx + 8'd1, cy + 8'd1), fx - one, fy - one);
    r = blend(blend(g0, g1, u), blend(g2, g3, u), v);
    return r[18:0];
  endfunction

  task automatic queue_beat(op_e op, logic [7:0] index, logic [7:0] value,
                            logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    beat_t b;
    b.op = op;
    b.index = index;
    b.value = value;
    b.x = x;
    b.y = y;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  function automatic logic [COORD_W-1:0] random_coord();
    logic [COORD_W-1:0] c;
    c = COORD_W'($urandom);
    // Push some fractions onto the ends of the fade curve.
    case ($urandom_range(7))
      0: c[FRAC_BITS-1:0] = '0;
      1: c[FRAC_BITS-1:0] = '1;
      default: ;
    endcase
    return c;
  endfunction

  task automatic queue_random_beat();
    if ($urandom_range(99) < 30) begin
      queue_beat(OP_WRITE, 8'($urandom), 8'($urandom), COORD_W'($urandom), COORD_W'($urandom));
    end else begin
      queue_beat(OP_SAMPLE, 8'($urandom), 8'($urandom), random_coord(), random_coord());
    end
  endtask

  task automatic wait_all_taken();
    while (beats_taken < beats_queued) @(posedge clk_i);
  endtask

  // Sender: a new beat is offered only once the current one has been taken.
  always @(negedge clk_i) begin : sender
    beat_t b;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_accepted) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        b = pending_beats.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= b.op;
        s_axis_tdata <= {b.y, b.x, b.value, b.index};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // One long hold-off on the result side so the pipeline fills and stalls input.
  always @(negedge clk_i) begin
    if (rst_ni && !hold_done && beats_taken >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || hold_left != 0) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : monitor
    logic [18:0] want;
    in_accepted = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_accepted = 1'b1;
        beats_taken++;
        if (op_e'(s_axis_tuser) == OP_WRITE) begin
          perm_copy[s_axis_tdata[7:0]] = s_axis_tdata[15:8];
          writes_taken++;
        end else begin
          expected_noise_q.push_back(noise_at(s_axis_tdata[39:16], s_axis_tdata[63:40]));
          samples_taken++;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_noise_q.size() == 0) begin
          $error("noise_value beat with nothing expected, got %0d",
                 $signed(m_axis_tdata[18:0]));
          errors++;
        end else begin
          want = expected_noise_q.pop_front();
          if (m_axis_tdata[18:0] !== want) begin
            $error("noise_value mismatch: expected %0d, got %0d",
                   $signed(want), $signed(m_axis_tdata[18:0]));
            errors++;
          end
          if (m_axis_tdata[23:19] !== 5'd0) begin
            $error("padding mismatch: expected 0, got %0h", m_axis_tdata[23:19]);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Identity table: every entry written, so no sample reads an unwritten one.
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      queue_beat(OP_WRITE, 8'(i), 8'(i), '0, '1);
    end
    // With the identity table the corner hash is cx + cy, so these walk all gradients.
    for (int k = 0; k < 8; k++) begin
      queue_beat(OP_SAMPLE, 8'hFF, 8'hFF, {8'(k), 16'h4000}, {8'd0, 16'hC000});
    end
    queue_beat(OP_SAMPLE, 8'h00, 8'h00, 24'h000000, 24'h000000);
    queue_beat(OP_SAMPLE, 8'hFF, 8'h00, 24'hFFFFFF, 24'hFFFFFF);
    queue_beat(OP_SAMPLE, 8'h00, 8'hFF, 24'h00FFFF, 24'h000000);
    queue_beat(OP_SAMPLE, 8'h5A, 8'hA5, 24'h7F8000, 24'h808000);
    queue_beat(OP_SAMPLE, 8'h00, 8'h00, 24'hFF0000, 24'h00FFFF);
    // Extreme writes with junk in the ignored coordinate bits.
    queue_beat(OP_WRITE, 8'hFF, 8'h00, 24'hFFFFFF, 24'hFFFFFF);
    queue_beat(OP_WRITE, 8'h00, 8'hFF, 24'hABCDEF, 24'h123456);
    queue_beat(OP_SAMPLE, 8'h00, 8'h00, 24'hFFC000, 24'hFF4000);
    queue_beat(OP_SAMPLE, 8'hFF, 8'hFF, 24'h00FFFF, 24'hFFFFFF);
    wait_all_taken();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) queue_random_beat();
      wait_all_taken();
    end

    while (expected_noise_q.size() != 0) @(posedge clk_i);
    repeat (NUM_STAGES + 10) @(posedge clk_i);
    $display("Covered %0d table writes and %0d samples (%0d results checked)",
             writes_taken, samples_taken, results_seen);
    $display("under free-running, sender-idle, receiver-stall and mixed handshakes.");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
